/* rtl/waveform_smooth_time_over_threshold_defines.svh */
// Assertion macros for the smoothing and time over threshold block.
// Each macro needs clk_i and rst_ni in the scope where it is used.
`ifndef WAVEFORM_SMOOTH_TIME_OVER_THRESHOLD_DEFINES_SVH
`define WAVEFORM_SMOOTH_TIME_OVER_THRESHOLD_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WSTO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSTO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSTO_ASSERT_IMP(lbl, ante, cons, msg)
`define WSTO_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/wsto_pkg.sv */
package wsto_pkg;

  // parameter defaults
  localparam int unsigned MAX_HALF_WINDOW_DEF = 15;
  localparam int unsigned MAX_SAMPLES_DEF     = 16384;
  localparam int unsigned NUM_THRESHOLDS_DEF  = 10;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned HW_W       = 4;
  localparam int unsigned BASE_W     = 24;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned BIN_W      = 14;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned THR_IDX_W  = 4;
  localparam int unsigned EDGE_OUT_W = 16;
  localparam int unsigned THR_MV_W   = 20;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_WINDOW = 3'd0,
    CFG_BASELINE    = 3'd1,
    CFG_GAIN        = 3'd2,
    CFG_MIN_THR     = 3'd3,
    CFG_THR_STEP    = 3'd4,
    CFG_DIG_THR     = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [HW_W-1:0]          RST_HALF_WINDOW = 4'd1;
  localparam logic signed [BASE_W-1:0] RST_BASELINE    = 24'sd0;
  localparam logic [GAIN_W-1:0]        RST_GAIN        = 32'd65536;
  localparam logic [MV_W-1:0]          RST_MIN_THR     = 16'd100;
  localparam logic [MV_W-1:0]          RST_THR_STEP    = 16'd25;
  localparam logic [MV_W-1:0]          RST_DIG_THR     = 16'd1500;

  // result kinds
  typedef enum logic {
    KIND_BIN     = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  localparam logic signed [VAL_W-1:0]      VAL_MIN   = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0]      VAL_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [EDGE_OUT_W-1:0] EDGE_NONE = -16'sd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_req_t;

  typedef struct packed {
    logic                         kind;
    logic [BIN_W-1:0]             bin_index;
    logic signed [VAL_W-1:0]      smoothed_q4;
    logic [THR_IDX_W-1:0]         threshold_index;
    logic signed [EDGE_OUT_W-1:0] leading_edge;
    logic signed [EDGE_OUT_W-1:0] falling_edge;
    logic signed [VAL_W-1:0]      amplitude_q4;
    logic                         last_result;
  } out_req_t;

  // edge status of one threshold cell
  typedef struct packed {
    logic signed [EDGE_OUT_W-1:0] leading;
    logic signed [EDGE_OUT_W-1:0] falling;
  } edge_t;

endpackage

/* rtl/wsto_dly_cell.sv */
module wsto_dly_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic signed [wsto_pkg::SAMPLE_W-1:0] d_i,
  output logic signed [wsto_pkg::SAMPLE_W-1:0] q_o
);
  import wsto_pkg::*;

  logic signed [SAMPLE_W-1:0] smp_q;

  // one tap of the sample line, takes its neighbor's value on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q <= '0;
    end else if (shift_i) begin
      smp_q <= d_i;
    end
  end

  assign q_o = smp_q;

endmodule

/* rtl/wsto_thr_cell.sv */
module wsto_thr_cell #(
  parameter int unsigned K       = 0,
  parameter bit          IS_LAST = 1'b0,
  parameter int unsigned EDGE_W  = 15
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   upd_i,
  input  logic                                   clr_i,
  input  logic signed [wsto_pkg::VAL_W-1:0]      val_i,
  input  logic [EDGE_W-1:0]                      edge_i,
  input  logic [wsto_pkg::MV_W-1:0]              min_i,
  input  logic [wsto_pkg::MV_W-1:0]              step_i,
  input  logic [wsto_pkg::MV_W-1:0]              dig_i,
  output wsto_pkg::edge_t                        edge_o
);
  import wsto_pkg::*;

  logic [THR_MV_W-1:0]     thr_mv;
  logic signed [VAL_W-1:0] thr_q4;
  logic                    above;
  logic                    found_q;
  logic [EDGE_W-1:0]       first_q;
  logic [EDGE_W-1:0]       last_q;

  // level of this threshold in mV, then Q4
  assign thr_mv = IS_LAST ? THR_MV_W'(dig_i)
                          : THR_MV_W'(min_i) + THR_MV_W'(step_i) * THR_MV_W'(K);
  assign thr_q4 = $signed({8'b0, thr_mv, 4'b0});
  assign above  = val_i > thr_q4;

  // first and last one-based bin strictly above the level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else if (clr_i) begin
      found_q <= 1'b0;
    end else if (upd_i && above) begin
      if (!found_q) begin
        found_q <= 1'b1;
        first_q <= edge_i;
      end
      last_q <= edge_i;
    end
  end

  assign edge_o.leading = found_q ? $signed(EDGE_OUT_W'(first_q)) : EDGE_NONE;
  assign edge_o.falling = found_q ? $signed(EDGE_OUT_W'(last_q)) : EDGE_NONE;

endmodule

/* rtl/waveform_smooth_time_over_threshold.sv */
// Channel   Direction  Handshake               Payload
// in        request    in_valid_i/in_stall_o   in_req_i  (sample, last_sample)
// out       result     out_valid_o/out_stall_i out_req_o (bin or threshold summary)
// cfg       write      cfg_we_i                cfg_idx_i, cfg_data_i
//
// A sample with no bin yet stays in S_IDLE, one whose bin is zero (edge bins)
// goes to S_EMIT; one yielding a computed bin passes S_DIFF, S_MUL, S_RND and
// S_DIV, where the restoring divider retires one quotient bit per cycle for the
// 1/W step, then S_EMIT. The final sample adds a result per trailing bin and
// per threshold summary. Reset is asynchronous, active low; no clearing pass.
// A stalled output holds the pending result and the state machine waits on it.
`include "waveform_smooth_time_over_threshold_defines.svh"

module waveform_smooth_time_over_threshold #(
  parameter int unsigned MAX_HALF_WINDOW = wsto_pkg::MAX_HALF_WINDOW_DEF,
  parameter int unsigned MAX_SAMPLES     = wsto_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned NUM_THRESHOLDS  = wsto_pkg::NUM_THRESHOLDS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  wsto_pkg::in_req_t                     in_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output wsto_pkg::out_req_t                    out_req_o,
  input  logic                                  cfg_we_i,
  input  logic [wsto_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [wsto_pkg::CFG_W-1:0]            cfg_data_i
);
  import wsto_pkg::*;

  localparam int unsigned DLY_N   = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned TAP_W   = (DLY_N > 1) ? $clog2(DLY_N) : 1;
  localparam int unsigned HWL_W   = (MAX_HALF_WINDOW > 0) ? $clog2(MAX_HALF_WINDOW + 1) : 1;
  localparam int unsigned WIN_W   = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned EDGE_W  = CNT_W + 1;
  localparam int unsigned SUM_W   = SAMPLE_W + 1 + $clog2(DLY_N);
  localparam int unsigned DIFF_W  = SUM_W + 10;
  localparam int unsigned PROD_W  = DIFF_W + GAIN_W;
  localparam int unsigned Q_W     = PROD_W + 1 - 20;
  localparam int unsigned IT_W    = $clog2(Q_W + 1);
  localparam int unsigned K_IDX_W = (NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_RND   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_TRAIL = 8'b0100_0000,
    S_SUM   = 8'b1000_0000
  } state_e;

  state_e st_q;

  // configuration registers
  logic [HW_W-1:0]          hw_cfg_q;
  logic signed [BASE_W-1:0] base_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [MV_W-1:0]          min_q;
  logic [MV_W-1:0]          step_q;
  logic [MV_W-1:0]          dig_q;

  // waveform state
  logic [CNT_W-1:0]         cnt_q;
  logic [HWL_W-1:0]         hw_q;
  logic                     last_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [VAL_W-1:0]  max_q;
  logic [CNT_W-1:0]         bin_q;
  logic [THR_IDX_W-1:0]     k_q;

  // calibration datapath
  logic signed [DIFF_W-1:0] diff_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [Q_W-1:0]           u_q;
  logic [WIN_W-1:0]         rem_q;
  logic [IT_W-1:0]          it_q;

  logic                     out_valid_q;
  out_req_t                 out_q;

  logic                     in_acc;
  logic                     can_load;
  logic                     out_load;
  logic                     last_in;
  logic [HWL_W-1:0]         h_sat;
  logic [HWL_W-1:0]         h_use;
  logic [WIN_W-1:0]         w_use;
  logic [WIN_W-1:0]         w_cur;
  logic signed [SAMPLE_W-1:0] dly_tap [DLY_N];
  logic signed [SAMPLE_W-1:0] leave;
  logic signed [SUM_W-1:0]  sum_base;
  logic signed [SUM_W-1:0]  leave_term;
  logic signed [SUM_W-1:0]  sum_d;
  logic [DIFF_W-1:0]        mag;
  logic [WIN_W:0]           trial;
  logic                     qbit;
  logic signed [VAL_W-1:0]  val_sat;
  logic signed [VAL_W-1:0]  cur_val;
  logic                     upd;
  logic                     clr;
  logic                     k_last;
  logic [EDGE_W-1:0]        edge_val;
  edge_t                    thr_edge [NUM_THRESHOLDS];
  edge_t                    sel_edge;

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign out_load   = can_load && (st_q inside {S_EMIT, S_TRAIL, S_SUM});
  assign last_in    = in_req_i.last_sample || (cnt_q == CNT_W'(MAX_SAMPLES - 1));

  // half window is latched on the first sample of a waveform
  assign h_sat = (32'(hw_cfg_q) > MAX_HALF_WINDOW) ? HWL_W'(MAX_HALF_WINDOW)
                                                    : HWL_W'(hw_cfg_q);
  assign h_use = (cnt_q == '0) ? h_sat : hw_q;
  assign w_use = WIN_W'(2 * 32'(h_use) + 1);
  assign w_cur = WIN_W'(2 * 32'(hw_q) + 1);

  // sample line: a row of cells shifting one tap per accepted sample
  for (genvar i = 0; i < DLY_N; i++) begin : g_dly
    if (i == 0) begin : g_head
      wsto_dly_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .d_i     (in_req_i.sample),
        .q_o     (dly_tap[i])
      );
    end else begin : g_body
      wsto_dly_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (in_acc),
        .d_i     (dly_tap[i-1]),
        .q_o     (dly_tap[i])
      );
    end
  end

  // running window sum: add the new sample, drop the one leaving the window
  assign leave      = dly_tap[TAP_W'(2 * 32'(h_use))];
  assign sum_base   = (cnt_q == '0) ? '0 : sum_q;
  assign leave_term = (32'(cnt_q) >= 32'(w_use)) ? SUM_W'(leave) : '0;
  assign sum_d      = sum_base + SUM_W'(in_req_i.sample) - leave_term;

  assign mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

  // one restoring divide step
  assign trial = {rem_q, u_q[Q_W-1]};
  assign qbit  = (trial >= (WIN_W + 1)'(w_cur));

  // signed saturation of the quotient
  always_comb begin
    if (neg_q) begin
      if (|u_q[Q_W-1:31]) begin
        val_sat = VAL_MIN;
      end else begin
        val_sat = -$signed({1'b0, u_q[30:0]});
      end
    end else begin
      if (|u_q[Q_W-1:31]) begin
        val_sat = VAL_MAX;
      end else begin
        val_sat = $signed({1'b0, u_q[30:0]});
      end
    end
  end

  assign cur_val  = (st_q == S_EMIT) ? val_sat : '0;
  assign upd      = can_load && ((st_q == S_EMIT) || (st_q == S_TRAIL));
  assign k_last   = (k_q == THR_IDX_W'(NUM_THRESHOLDS - 1));
  assign clr      = can_load && (st_q == S_SUM) && k_last;
  assign edge_val = EDGE_W'(bin_q) + EDGE_W'(1);

  // threshold cells, one per level
  for (genvar k = 0; k < NUM_THRESHOLDS; k++) begin : g_thr
    wsto_thr_cell #(
      .K       (k),
      .IS_LAST (k == NUM_THRESHOLDS - 1),
      .EDGE_W  (EDGE_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .upd_i  (upd),
      .clr_i  (clr),
      .val_i  (cur_val),
      .edge_i (edge_val),
      .min_i  (min_q),
      .step_i (step_q),
      .dig_i  (dig_q),
      .edge_o (thr_edge[k])
    );
  end

  assign sel_edge = thr_edge[k_q[K_IDX_W-1:0]];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_cfg_q <= RST_HALF_WINDOW;
      base_q   <= RST_BASELINE;
      gain_q   <= RST_GAIN;
      min_q    <= RST_MIN_THR;
      step_q   <= RST_THR_STEP;
      dig_q    <= RST_DIG_THR;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_WINDOW: hw_cfg_q <= cfg_data_i[HW_W-1:0];
        CFG_BASELINE:    base_q   <= $signed(cfg_data_i[BASE_W-1:0]);
        CFG_GAIN:        gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_MIN_THR:     min_q    <= cfg_data_i[MV_W-1:0];
        CFG_THR_STEP:    step_q   <= cfg_data_i[MV_W-1:0];
        CFG_DIG_THR:     dig_q    <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and waveform state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      hw_q        <= '0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      max_q       <= VAL_MIN;
      k_q         <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output valid: set on a load, cleared once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            hw_q   <= h_use;
            last_q <= last_in;
            sum_q  <= sum_d;
            if (32'(cnt_q) >= 32'(h_use)) begin
              if (32'(cnt_q) >= 2 * 32'(h_use)) begin
                st_q <= S_DIFF;
              end else begin
                st_q <= S_EMIT;
              end
            end else if (last_in) begin
              st_q <= S_TRAIL;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        S_DIFF: st_q <= S_MUL;
        S_MUL:  st_q <= S_RND;
        S_RND: begin
          it_q <= '0;
          st_q <= S_DIV;
        end
        S_DIV: begin
          it_q <= it_q + IT_W'(1);
          if (it_q == IT_W'(Q_W - 1)) begin
            st_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            if (cur_val > max_q) begin
              max_q <= cur_val;
            end
            if (last_q) begin
              k_q <= '0;
              st_q <= (hw_q == '0) ? S_SUM : S_TRAIL;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
              st_q  <= S_IDLE;
            end
          end
        end
        S_TRAIL: begin
          if (can_load) begin
            if (cur_val > max_q) begin
              max_q <= cur_val;
            end
            if (bin_q == cnt_q) begin
              k_q  <= '0;
              st_q <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (can_load) begin
            if (k_last) begin
              cnt_q <= '0;
              max_q <= VAL_MIN;
              st_q  <= S_IDLE;
            end else begin
              k_q <= k_q + THR_IDX_W'(1);
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_q <= 1'b0;
          u_q   <= '0;
          if (32'(cnt_q) >= 32'(h_use)) begin
            bin_q <= CNT_W'(32'(cnt_q) - 32'(h_use));
          end else begin
            bin_q <= '0;
          end
        end
      end
      S_DIFF: begin
        diff_q <= (DIFF_W'(sum_q) <<< 8)
                  - DIFF_W'($signed({1'b0, w_cur}) * base_q);
      end
      S_MUL: begin
        neg_q  <= diff_q[DIFF_W-1];
        prod_q <= PROD_W'(mag) * PROD_W'(gain_q);
      end
      S_RND: begin
        u_q   <= Q_W'(((PROD_W + 1)'(prod_q) + ((PROD_W + 1)'(w_cur) << 19)) >> 20);
        rem_q <= '0;
      end
      S_DIV: begin
        rem_q <= qbit ? WIN_W'(trial - (WIN_W + 1)'(w_cur)) : WIN_W'(trial);
        u_q   <= {u_q[Q_W-2:0], qbit};
      end
      S_EMIT: begin
        if (can_load) begin
          out_q.kind            <= KIND_BIN;
          out_q.bin_index       <= BIN_W'(bin_q);
          out_q.smoothed_q4     <= cur_val;
          out_q.threshold_index <= '0;
          out_q.leading_edge    <= '0;
          out_q.falling_edge    <= '0;
          out_q.amplitude_q4    <= '0;
          out_q.last_result     <= 1'b0;
          if (last_q) begin
            bin_q <= bin_q + CNT_W'(1);
          end
        end
      end
      S_TRAIL: begin
        if (can_load) begin
          out_q.kind            <= KIND_BIN;
          out_q.bin_index       <= BIN_W'(bin_q);
          out_q.smoothed_q4     <= '0;
          out_q.threshold_index <= '0;
          out_q.leading_edge    <= '0;
          out_q.falling_edge    <= '0;
          out_q.amplitude_q4    <= '0;
          out_q.last_result     <= 1'b0;
          bin_q                 <= bin_q + CNT_W'(1);
        end
      end
      S_SUM: begin
        if (can_load) begin
          out_q.kind            <= KIND_SUMMARY;
          out_q.bin_index       <= '0;
          out_q.smoothed_q4     <= '0;
          out_q.threshold_index <= k_q;
          out_q.leading_edge    <= sel_edge.leading;
          out_q.falling_edge    <= sel_edge.falling;
          out_q.amplitude_q4    <= max_q;
          out_q.last_result     <= k_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // checks
  `WSTO_ASSERT_IMP(a_last_is_summary, out_valid_o && out_req_o.last_result, out_req_o.kind == KIND_SUMMARY && out_req_o.threshold_index == THR_IDX_W'(NUM_THRESHOLDS - 1), "last result must be the final threshold summary")
  `WSTO_ASSERT_IMP(a_div_rem, st_q == S_DIV, rem_q < w_cur, "divider remainder not below window length")
  `WSTO_ASSERT_IMP(a_trail_range, st_q == S_TRAIL, bin_q <= cnt_q, "trailing bin past last sample")
  `WSTO_ASSERT_NXT(a_wave_clear, clr, cnt_q == '0 && max_q == VAL_MIN && st_q == S_IDLE, "waveform state not cleared after summaries")

endmodule
